/* design/cdm_pkg.sv */
// Shared types, constants and codes for the clock display multiplexer.
package cdm_pkg;

   localparam int unsigned DIGIT_COUNT = 4;

   localparam logic [2:0] MODE_NORMAL      = 3'd0;
   localparam logic [2:0] MODE_SET_HOURS   = 3'd1;
   localparam logic [2:0] MODE_SET_MINUTES = 3'd2;
   localparam logic [2:0] MODE_MIN_SEC     = 3'd3;
   localparam logic [2:0] MODE_SET_BOTH    = 3'd4;
   localparam logic [2:0] MODE_HOLD        = 3'd5;

   localparam logic [2:0] CSR_BLINK_THRESHOLD_ADDR = 3'd0;
   localparam logic [7:0] BLINK_THRESHOLD_RESET    = 8'd100;
   localparam logic       DOT_PIN_RESET            = 1'b1;

   typedef struct packed {
      logic       dots_off;
      logic [7:0] blink_count;
      logic [2:0] display_mode;
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [4:0] hours;
   } req_item_type;

   typedef struct packed {
      logic [1:0] slot_index;
      logic       dot_level;
      logic [3:0] anode_enable;
      logic [3:0] digit_bcd;
   } rsp_item_type;

   typedef struct packed {
      logic       step;
      logic [7:0] blink_threshold;
   } core_ctrl_type;

endpackage

/* design/cdm_digit_split.sv */
// Splits a value of 0 to 63 into its decimal tens and units digits.
module cdm_digit_split (
   input  logic [5:0] value,
   output logic [3:0] tens,
   output logic [3:0] units
);
   logic [2:0] tens_raw;
   logic [6:0] tens_times_ten;
   logic [6:0] remainder;

   always_comb begin
      if (value >= 6'd60) begin
         tens_raw = 3'd6;
      end else if (value >= 6'd50) begin
         tens_raw = 3'd5;
      end else if (value >= 6'd40) begin
         tens_raw = 3'd4;
      end else if (value >= 6'd30) begin
         tens_raw = 3'd3;
      end else if (value >= 6'd20) begin
         tens_raw = 3'd2;
      end else if (value >= 6'd10) begin
         tens_raw = 3'd1;
      end else begin
         tens_raw = 3'd0;
      end
   end

   assign tens_times_ten = {1'b0, tens_raw, 3'b000} + {3'b000, tens_raw, 1'b0};
   assign remainder      = {1'b0, value} - tens_times_ten;
   assign tens           = {1'b0, tens_raw};
   assign units          = remainder[3:0];

endmodule

/* design/cdm_core.sv */
// Held digits, slot counter, dot pin and the per-tick digit, blank and blink logic.
module cdm_core (
   input  logic                  clock,
   input  logic                  reset,
   input  cdm_pkg::core_ctrl_type ctrl,
   input  cdm_pkg::req_item_type item,
   output cdm_pkg::rsp_item_type result
);
   import cdm_pkg::*;

   logic [3:0] held_ff [DIGIT_COUNT];
   logic [3:0] held_in [DIGIT_COUNT];
   logic [1:0] slot_ff;
   logic [1:0] slot_in;
   logic       dot_ff;
   logic       dot_in;

   logic [5:0] high_value;
   logic [5:0] low_value;
   logic [3:0] high_tens;
   logic [3:0] high_units;
   logic [3:0] low_tens;
   logic [3:0] low_units;
   logic       blink_on;
   logic       lit;

   always_comb begin
      if (item.display_mode == MODE_MIN_SEC) begin
         high_value = item.minutes;
         low_value  = item.seconds;
      end else begin
         high_value = {1'b0, item.hours};
         low_value  = item.minutes;
      end
   end

   cdm_digit_split u_split_high (
      .value (high_value),
      .tens  (high_tens),
      .units (high_units)
   );

   cdm_digit_split u_split_low (
      .value (low_value),
      .tens  (low_tens),
      .units (low_units)
   );

   assign blink_on = item.blink_count <= ctrl.blink_threshold;

   always_comb begin
      if (item.display_mode == MODE_HOLD) begin
         held_in = held_ff;
      end else begin
         held_in[0] = high_tens;
         held_in[1] = high_units;
         held_in[2] = low_tens;
         held_in[3] = low_units;
      end

      dot_in  = dot_ff;
      slot_in = slot_ff + 2'd1;

      if (!slot_ff[1]) begin
         if (item.display_mode == MODE_SET_HOURS || item.display_mode == MODE_SET_BOTH) begin
            lit = blink_on;
         end else begin
            lit = 1'b1;
         end
         if (slot_ff == 2'd0 && item.display_mode == MODE_NORMAL && held_in[0] == 4'd0) begin
            lit = 1'b0;
         end
         if (slot_ff == 2'd1 && item.display_mode == MODE_NORMAL) begin
            dot_in = item.dots_off;
         end
      end else begin
         if (item.display_mode == MODE_SET_MINUTES || item.display_mode == MODE_SET_BOTH) begin
            lit = blink_on;
         end else begin
            lit = 1'b1;
         end
      end

      result.digit_bcd    = held_in[slot_ff];
      result.anode_enable = lit ? (4'b0001 << slot_ff) : 4'b0000;
      result.dot_level    = dot_in;
      result.slot_index   = slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            held_ff[i] <= 4'd0;
         end
         slot_ff <= 2'd0;
         dot_ff  <= DOT_PIN_RESET;
      end else if (ctrl.step) begin
         held_ff <= held_in;
         slot_ff <= slot_in;
         dot_ff  <= dot_in;
      end
   end

   a_slot_advance : assert property (@(posedge clock) disable iff (reset)
      ctrl.step |=> slot_ff == $past(slot_ff) + 2'd1)
      else $error("slot counter did not advance by one");

   a_slot_stall : assert property (@(posedge clock) disable iff (reset)
      !ctrl.step |=> $stable(slot_ff) && $stable(dot_ff))
      else $error("state moved without a transaction");

   a_hold_keeps_digits : assert property (@(posedge clock) disable iff (reset)
      (ctrl.step && item.display_mode == MODE_HOLD) |=>
         held_ff[0] == $past(held_ff[0]) && held_ff[1] == $past(held_ff[1]) &&
         held_ff[2] == $past(held_ff[2]) && held_ff[3] == $past(held_ff[3]))
      else $error("held digits changed in hold mode");

   a_dot_only_normal_slot1 : assert property (@(posedge clock) disable iff (reset)
      (ctrl.step && !(item.display_mode == MODE_NORMAL && slot_ff == 2'd1)) |=>
         $stable(dot_ff))
      else $error("dot pin changed outside normal mode slot one");

   a_anode_matches_slot : assert property (@(posedge clock) disable iff (reset)
      ctrl.step |-> (result.anode_enable == 4'b0000 ||
                     result.anode_enable == (4'b0001 << slot_ff)))
      else $error("anode enable does not match the driven slot");

endmodule

/* design/clock_display_multiplexer.sv */
// Top level of the clock display multiplexer: stream ports, register port and pipeline.
//
// One request transaction is one refresh tick. It carries the time of day, the display
// mode, the blink phase count and the dots control; it drives one of four tube positions
// in turn, chosen by an internal slot counter that wraps from 3 to 0.
// Each request gives exactly one response: the BCD digit of the driven position, the
// one-hot anode enable (zero when blanked), the dot pin level and the slot index.
// A request passes through one input register, then the digit, blank and blink logic,
// then the response register. A request is taken every cycle; throughput is one
// transaction per cycle, limited by nothing but the output handshake.
// When the receiver stalls, both stages hold and req_tready falls only once both are full.
// Reset clears the held digits and slot counter, sets the dot pin to off and the blink
// threshold to 100; no clearing pass is needed. The blink threshold register sits at
// address 0 of the csr port and must be written only while the block is idle.
module clock_display_multiplexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // hours[4:0], minutes[10:5], seconds[16:11], display_mode[19:17],
   // blink_count[27:20], dots_off[28], zero fill [31:29]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // digit_bcd[3:0], anode_enable[7:4], dot_level[8], slot_index[10:9], zero fill [15:11]
   output logic [15:0] rsp_tdata,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import cdm_pkg::*;

   logic          in_valid_ff;
   logic          in_valid_in;
   req_item_type  in_item_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   rsp_item_type  out_item_ff;
   rsp_item_type  core_result;
   core_ctrl_type core_ctrl;
   logic [7:0]    threshold_ff;
   logic          advance;
   logic          csr_write;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   assign core_ctrl.step            = in_valid_ff && advance;
   assign core_ctrl.blink_threshold = threshold_ff;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   cdm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (core_ctrl),
      .item   (in_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_tdata[28:0];
      end
      if (core_ctrl.step) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_item_ff};

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= BLINK_THRESHOLD_RESET;
      end else if (csr_write && paddr == CSR_BLINK_THRESHOLD_ADDR) begin
         threshold_ff <= pwdata[7:0];
      end
   end

   always_comb begin
      if (paddr == CSR_BLINK_THRESHOLD_ADDR) begin
         prdata = {24'd0, threshold_ff};
      end else begin
         prdata = 32'd0;
      end
   end

endmodule
